>>> rtl/ppsteer_pkg.sv
// package: constants, types and helper functions for the pure pursuit steering block
package ppsteer_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int COEFF_FRAC_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CORDIC_W   = 40;

  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 2'd3;

  localparam logic [15:0] LOOKAHEAD_RST = 16'd1280;
  localparam logic [15:0] WHEELBASE_RST = 16'd768;
  localparam logic [5:0]  RATIO_RST     = 6'd12;
  localparam logic [15:0] SPEED_RST     = 16'd2560;

  localparam logic signed [65:0] ACC_LIM         = 66'sd1 <<< 46;
  localparam logic signed [63:0] ANGLE_LIM       = 64'sd276480;
  localparam logic signed [63:0] DEG_PER_RAD_Q24 = 64'sd961263669;
  localparam logic [31:0]        QUARTER_PI_Q30  = 32'd843314857;

  typedef struct packed {
    logic signed [47:0] val;
    logic               sat;
  } acc_clip_t;

  function automatic logic signed [47:0] clip_acc(input logic signed [65:0] v,
                                                  inout logic sat);
    logic signed [65:0] r;
    r = v;
    if (v < -ACC_LIM) begin
      r = -ACC_LIM;
      sat = 1'b1;
    end else if (v > ACC_LIM) begin
      r = ACC_LIM;
      sat = 1'b1;
    end
    return r[47:0];
  endfunction

  // shift the product, clip, add the next coefficient, clip again
  function automatic acc_clip_t horner_add(input logic signed [65:0] prod,
                                           input logic signed [31:0] coeff,
                                           input logic sat_in);
    acc_clip_t res;
    logic sat;
    logic signed [47:0] a;
    sat = sat_in;
    a = clip_acc(prod >>> 8, sat);
    res.val = clip_acc(66'(a) + 66'(coeff), sat);
    res.sat = sat;
    return res;
  endfunction

  // elaboration-time division, shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q2.30, rounded to nearest
  function automatic logic [31:0] atan_pow2(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned k;
    if (i == 0) return QUARTER_PI_Q30;
    sum = '0;
    for (k = 0; (2 * k + 1) * i <= 62; k++) begin
      term = udiv64(64'd1 << (62 - (2 * k + 1) * i), 64'(2 * k + 1));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
    end
    sum = (sum + (64'd1 << 31)) >> 32;
    return sum[31:0];
  endfunction

endpackage

>>> rtl/ppsteer_if.sv
// interfaces: lane coefficient channel and steering command channel
interface ppsteer_lane_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cubic_coeff;
  logic signed [31:0] quadratic_coeff;
  logic signed [31:0] linear_coeff;
  logic signed [31:0] constant_coeff;

  modport source(output valid, cubic_coeff, quadratic_coeff, linear_coeff,
                 constant_coeff, input ready);
  modport sink(input valid, cubic_coeff, quadratic_coeff, linear_coeff,
               constant_coeff, output ready);
endinterface

interface ppsteer_steer_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] wheel_angle_deg;
  logic        [15:0] speed_command;
  logic               saturated;

  modport source(output valid, wheel_angle_deg, speed_command, saturated, input ready);
  modport sink(input valid, wheel_angle_deg, speed_command, saturated, output ready);
endinterface

>>> rtl/pure_pursuit_steering.sv
// top level: pipelined pure pursuit steering law
// usage:
//   lane carries the four lane polynomial coefficients of one fit; a transfer
//   takes place when valid and ready are both high. steer returns one command
//   per fit: wheel angle in Q12.8 degrees, the speed register and a clip flag.
//   the four registers are written through cfg_we, cfg_index and cfg_data; the user
//   must write them only while nothing is in flight, the block does not enforce it.
//   the pipeline has eight stages of Horner and squaring, one setup stage, one
//   CORDIC stage per iteration, one degree multiply and the output register.
//   throughput is one fit per cycle while steer is not stalled, set by the
//   one-stage-per-iteration CORDIC and the split 48 by 16 bit Horner multiplies.
//   when steer is stalled the whole pipeline holds and lane.ready drops; no
//   fit is lost or repeated.
//   rst (synchronous) empties the pipeline and loads the register defaults.
module pure_pursuit_steering #(
  parameter int CORDIC_STEPS    = ppsteer_pkg::CORDIC_STEPS_DEF,
  parameter int COEFF_FRAC_BITS = ppsteer_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  ppsteer_lane_if.sink                       lane,
  ppsteer_steer_if.source                    steer,
  input  logic                               cfg_we,
  input  logic [ppsteer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppsteer_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int SH = COEFF_FRAC_BITS - 8;
  localparam int CW = ppsteer_pkg::CORDIC_W;

  logic [15:0] lookahead;
  logic [15:0] wheelbase;
  logic [5:0]  ratio;
  logic [15:0] speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= ppsteer_pkg::LOOKAHEAD_RST;
      wheelbase <= ppsteer_pkg::WHEELBASE_RST;
      ratio     <= ppsteer_pkg::RATIO_RST;
      speed     <= ppsteer_pkg::SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppsteer_pkg::REG_LOOKAHEAD: lookahead <= cfg_data[15:0];
        ppsteer_pkg::REG_WHEELBASE: wheelbase <= cfg_data[15:0];
        ppsteer_pkg::REG_RATIO:     ratio     <= cfg_data[5:0];
        ppsteer_pkg::REG_SPEED:     speed     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !steer.valid || steer.ready;
  assign lane.ready = en;

  logic signed [16:0] xs;
  assign xs = $signed({1'b0, lookahead});

  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic s2, s3, s4, s5, s6, s7, s8;
  logic signed [48:0] m1;
  logic signed [31:0] c2_1, c1_1, c0_1, c1_2, c0_2, c1_3, c0_3, c0_4, c0_5;
  logic signed [47:0] a2, a4, a6;
  logic signed [40:0] ph3, ph5;
  logic        [39:0] pl3, pl5;
  logic signed [15:0] gy7;
  logic signed [31:0] gg8;
  logic signed [32:0] wg8;
  logic        [31:0] xx8;

  ppsteer_pkg::acc_clip_t h2, h4, h6;
  logic signed [48:0] gr;
  logic signed [15:0] gy_next;
  logic               gsat;

  always_comb begin
    h2 = ppsteer_pkg::horner_add(66'(m1), c2_1, 1'b0);
    h4 = ppsteer_pkg::horner_add((66'(ph3) <<< 24) + 66'($signed({1'b0, pl3})), c1_3, s3);
    h6 = ppsteer_pkg::horner_add((66'(ph5) <<< 24) + 66'($signed({1'b0, pl5})), c0_5, s5);
    gr = (49'(a6) + (49'sd1 <<< (SH - 1))) >>> SH;
    gsat = s6;
    if (gr < -49'sd32768) begin
      gy_next = -16'sd32768;
      gsat = 1'b1;
    end else if (gr > 49'sd32767) begin
      gy_next = 16'sd32767;
      gsat = 1'b1;
    end else begin
      gy_next = gr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= {lane.valid, v1, v2, v3, v4, v5, v6, v7};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= lane.cubic_coeff * xs;
      c2_1 <= lane.quadratic_coeff;
      c1_1 <= lane.linear_coeff;
      c0_1 <= lane.constant_coeff;
      a2   <= h2.val;
      s2   <= h2.sat;
      c1_2 <= c1_1;
      c0_2 <= c0_1;
      ph3  <= $signed(a2[47:24]) * xs;
      pl3  <= a2[23:0] * lookahead;
      s3   <= s2;
      c1_3 <= c1_2;
      c0_3 <= c0_2;
      a4   <= h4.val;
      s4   <= h4.sat;
      c0_4 <= c0_3;
      ph5  <= $signed(a4[47:24]) * xs;
      pl5  <= a4[23:0] * lookahead;
      s5   <= s4;
      c0_5 <= c0_4;
      a6   <= h6.val;
      s6   <= h6.sat;
      gy7  <= gy_next;
      s7   <= gsat;
      gg8  <= gy7 * gy7;
      wg8  <= $signed({1'b0, wheelbase}) * gy7;
      xx8  <= lookahead * lookahead;
      s8   <= s7;
    end
  end

  logic signed [CW-1:0] cx [0:CORDIC_STEPS];
  logic signed [CW-1:0] cy [0:CORDIC_STEPS];
  logic signed [31:0]   zc [0:CORDIC_STEPS];
  logic                 vc [0:CORDIC_STEPS];
  logic                 sc [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc[0] <= 1'b0;
    end else if (en) begin
      vc[0] <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= CW'($signed({1'b0, xx8})) + CW'(gg8);
      cy[0] <= CW'(wg8) <<< 1;
      zc[0] <= '0;
      sc[0] <= s8;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [31:0] ATAN = $signed(ppsteer_pkg::atan_pow2(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        vc[i+1] <= 1'b0;
      end else if (en) begin
        vc[i+1] <= vc[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sc[i+1] <= sc[i];
        if (cy[i] >= 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          zc[i+1] <= zc[i] + ATAN;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          zc[i+1] <= zc[i] - ATAN;
        end
      end
    end
  end

  logic               vd;
  logic               sd;
  logic signed [63:0] dp;
  logic signed [63:0] t;
  logic signed [19:0] ang_next;
  logic               asat;

  always_comb begin
    t = (dp >>> 30) * $signed({58'd0, ratio});
    t = (t + 64'sd32768) >>> 16;
    asat = sd;
    if (t < -ppsteer_pkg::ANGLE_LIM) begin
      ang_next = -20'sd276480;
      asat = 1'b1;
    end else if (t > ppsteer_pkg::ANGLE_LIM) begin
      ang_next = 20'sd276480;
      asat = 1'b1;
    end else begin
      ang_next = t[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd          <= 1'b0;
      steer.valid <= 1'b0;
    end else if (en) begin
      vd          <= vc[CORDIC_STEPS];
      steer.valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp                    <= 64'(zc[CORDIC_STEPS]) * ppsteer_pkg::DEG_PER_RAD_Q24;
      sd                    <= sc[CORDIC_STEPS];
      steer.wheel_angle_deg <= ang_next;
      steer.speed_command   <= speed;
      steer.saturated       <= asat;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !steer.valid)
    else $error("result valid right after reset");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    steer.valid |-> (steer.wheel_angle_deg <= 20'sd276480 &&
                     steer.wheel_angle_deg >= -20'sd276480))
    else $error("wheel angle beyond limit");
  a_zero_ratio: assert property (@(posedge clk) disable iff (rst)
    (steer.valid && ratio == 6'd0) |-> steer.wheel_angle_deg == 20'sd0)
    else $error("nonzero angle with zero steering ratio");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (steer.valid && !steer.ready) |=> ($stable(vd) && $stable(vc[CORDIC_STEPS])))
    else $error("pipeline moved during a stall");

endmodule

>>> tb/ppsteer_checker.sv
// checker: predicts each steering command from the lane transfers and compares
`timescale 1ns / 100ps
module ppsteer_checker #(
  parameter int CORDIC_STEPS    = ppsteer_pkg::CORDIC_STEPS_DEF,
  parameter int COEFF_FRAC_BITS = ppsteer_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  ppsteer_lane_if                            lane,
  ppsteer_steer_if                           steer,
  input  logic                               cfg_we,
  input  logic [ppsteer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppsteer_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                 err_count,
  output int                                 pending
);

  typedef struct {
    logic signed [19:0] angle;
    logic        [15:0] speed;
    logic               sat;
  } steer_cmd_t;

  localparam longint HORNER_LIM = longint'(1) <<< 46;

  logic [15:0] lookahead_q, wheelbase_q, speed_q;
  logic [5:0]  ratio_q;
  steer_cmd_t  cmd_queue[$];
  longint      atan_q30[64];

  function automatic longint clamp(longint v, longint lo, longint hi, inout bit hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic longint arctan_step(int unsigned i);
    longint unsigned acc;
    longint unsigned term;
    int unsigned k;
    acc = 0;
    if (i == 0) return 64'd843314857;
    for (k = 0; (2 * k + 1) * i <= 62; k++) begin
      term = (longint'(1) << (62 - (2 * k + 1) * i)) / longint'(2 * k + 1);
      if (k % 2) acc = acc - term;
      else acc = acc + term;
    end
    return longint'((acc + (longint'(1) << 31)) >> 32);
  endfunction

  initial begin
    for (int i = 0; i < 64; i++) atan_q30[i] = arctan_step(i);
  end

  function automatic steer_cmd_t steer_law(logic signed [31:0] c3, logic signed [31:0] c2,
                                           logic signed [31:0] c1, logic signed [31:0] c0);
    steer_cmd_t r;
    bit hit;
    longint x, acc, gy, cx, cy, z, t, dx, dy;
    hit = 1'b0;
    x = longint'(lookahead_q);
    acc = longint'(c3);
    acc = clamp((acc * x) >>> 8, -HORNER_LIM, HORNER_LIM, hit);
    acc = clamp(acc + longint'(c2), -HORNER_LIM, HORNER_LIM, hit);
    acc = clamp((acc * x) >>> 8, -HORNER_LIM, HORNER_LIM, hit);
    acc = clamp(acc + longint'(c1), -HORNER_LIM, HORNER_LIM, hit);
    acc = clamp((acc * x) >>> 8, -HORNER_LIM, HORNER_LIM, hit);
    acc = clamp(acc + longint'(c0), -HORNER_LIM, HORNER_LIM, hit);
    gy = (acc + (longint'(1) <<< (COEFF_FRAC_BITS - 9))) >>> (COEFF_FRAC_BITS - 8);
    gy = clamp(gy, -32768, 32767, hit);
    cx = x * x + gy * gy;
    cy = 2 * longint'(wheelbase_q) * gy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 63; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        z += atan_q30[i];
      end else begin
        cx -= dx;
        cy += dy;
        z -= atan_q30[i];
      end
    end
    t = (z * 64'sd961263669) >>> 30;
    t = t * longint'(ratio_q);
    t = (t + (longint'(1) <<< 15)) >>> 16;
    t = clamp(t, -276480, 276480, hit);
    r.angle = t[19:0];
    r.speed = speed_q;
    r.sat = hit;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  initial err_count = 0;
  assign pending = cmd_queue.size();

  always @(posedge clk) begin
    steer_cmd_t e;
    if (rst) begin
      lookahead_q <= ppsteer_pkg::LOOKAHEAD_RST;
      wheelbase_q <= ppsteer_pkg::WHEELBASE_RST;
      ratio_q     <= ppsteer_pkg::RATIO_RST;
      speed_q     <= ppsteer_pkg::SPEED_RST;
      cmd_queue.delete();
    end else begin
      if (lane.valid && lane.ready)
        cmd_queue.push_back(steer_law(lane.cubic_coeff, lane.quadratic_coeff,
                                      lane.linear_coeff, lane.constant_coeff));
      if (steer.valid && steer.ready) begin
        if (cmd_queue.size() == 0) begin
          report("unexpected command", longint'(steer.wheel_angle_deg), 0);
        end else begin
          e = cmd_queue.pop_front();
          if (steer.wheel_angle_deg !== e.angle)
            report("wheel_angle_deg", longint'(steer.wheel_angle_deg), longint'(e.angle));
          if (steer.speed_command !== e.speed)
            report("speed_command", longint'(steer.speed_command), longint'(e.speed));
          if (steer.saturated !== e.sat)
            report("saturated", longint'(steer.saturated), longint'(e.sat));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ppsteer_pkg::REG_LOOKAHEAD: lookahead_q <= cfg_data;
          ppsteer_pkg::REG_WHEELBASE: wheelbase_q <= cfg_data;
          ppsteer_pkg::REG_RATIO:     ratio_q     <= cfg_data[5:0];
          ppsteer_pkg::REG_SPEED:     speed_q     <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

>>> tb/tb_pure_pursuit_steering.sv
// testbench top: clock, reset, lane and register stimulus, verdict
`timescale 1ns / 100ps
module tb_pure_pursuit_steering;

  localparam int DRAIN_CYCLES = ppsteer_pkg::CORDIC_STEPS_DEF + 30;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ppsteer_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ppsteer_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int   err_count, pending;
  int   cycles = 0;
  bit   no_idle = 1'b0;

  ppsteer_lane_if  lane_ch();
  ppsteer_steer_if steer_ch();

  initial begin
    lane_ch.valid = 1'b0;
    lane_ch.cubic_coeff = '0;
    lane_ch.quadratic_coeff = '0;
    lane_ch.linear_coeff = '0;
    lane_ch.constant_coeff = '0;
    steer_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  pure_pursuit_steering DUT (
    .clk(clk), .rst(rst), .lane(lane_ch), .steer(steer_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ppsteer_checker u_checker (
    .clk(clk), .rst(rst), .lane(lane_ch), .steer(steer_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .err_count(err_count), .pending(pending)
  );

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // command side stalls
  initial begin
    int g;
    @(posedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        steer_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      steer_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic write_reg(logic [ppsteer_pkg::CFG_IDX_W-1:0] idx,
                           logic [ppsteer_pkg::CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] la, logic [15:0] wb, logic [15:0] ra,
                           logic [15:0] sp);
    write_reg(ppsteer_pkg::REG_LOOKAHEAD, la);
    write_reg(ppsteer_pkg::REG_WHEELBASE, wb);
    write_reg(ppsteer_pkg::REG_RATIO, ra);
    write_reg(ppsteer_pkg::REG_SPEED, sp);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_fit(logic [31:0] c3, logic [31:0] c2, logic [31:0] c1,
                          logic [31:0] c0);
    int g;
    lane_ch.valid <= 1'b1;
    lane_ch.cubic_coeff <= c3;
    lane_ch.quadratic_coeff <= c2;
    lane_ch.linear_coeff <= c1;
    lane_ch.constant_coeff <= c0;
    @(posedge clk);
    while (!lane_ch.ready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      lane_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    lane_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // lane-like coefficient: full range shifted down by a random amount
  function automatic logic [31:0] lane_coeff();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  task automatic directed_fits();
    send_fit(0, 0, 0, 0);
    send_fit(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_fit(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_fit(0, 0, 0, 32'h7fffffff);
    send_fit(0, 0, 0, 32'h80000000);
    send_fit(0, 0, 32'h7fffffff, 0);
    send_fit(0, 32'h80000000, 0, 0);
    send_fit(32'h7fffffff, 0, 0, 32'h80000000);
    send_fit(0, 0, 0, 32'h01000000);
    send_fit(0, 0, 0, 32'hff000000);
    send_fit(0, 0, 0, 32'h00008000);
    send_fit(0, 0, 0, 32'h00007fff);
    send_fit(32'hffffffff, 32'h00000001, 32'hffffffff, 32'h00000001);
    send_fit(32'h00010000, 32'hfff00000, 32'h00400000, 32'hfe000000);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    no_idle = 1'b1;
    directed_fits();
    drain();
    no_idle = 1'b0;
    load_regs(16'd0, 16'd768, 16'd12, 16'd0);
    directed_fits();
    drain();
    load_regs(16'd65535, 16'd65535, 16'hffc0, 16'd65535);
    directed_fits();
    drain();
    load_regs(16'd256, 16'd0, 16'd63, 16'd1);
    directed_fits();
    drain();
    load_regs(16'd1024, 16'd65535, 16'd63, 16'h5a5a);
    directed_fits();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 3);
      load_regs((ph % 4 == 0) ? 16'($urandom) : 16'($urandom_range(256, 3000)),
                (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(256, 1200)),
                16'($urandom),
                16'($urandom));
      repeat (100) begin
        if ($urandom_range(0, 9) < 8)
          send_fit(lane_coeff(), lane_coeff(), lane_coeff(), lane_coeff());
        else
          send_fit($urandom, $urandom, $urandom, $urandom);
      end
      drain();
    end

    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> sim.f
rtl/ppsteer_pkg.sv
rtl/ppsteer_if.sv
rtl/pure_pursuit_steering.sv
tb/ppsteer_checker.sv
tb/tb_pure_pursuit_steering.sv
